[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: request and
// error codes, result kinds and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int unsigned MAX_BLOCKS_DEF  = 1024;
	localparam int unsigned BLOCK_BYTES_DEF = 4096;

	// bitmap is stored as words of this many block flags
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned BIT_W     = $clog2(WORD_BITS);

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned ERR_W   = 2;
	localparam int unsigned OUT_W   = 56;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		CFG_POOL_BASE   = 1'b0,
		CFG_POOL_BLOCKS = 1'b1
	} cfg_idx_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 2'd0,
		ERR_FULL      = 2'd1,
		ERR_NOT_ALLOC = 2'd2,
		ERR_RANGE     = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		RES_ALLOC     = 3'd0,
		RES_FULL      = 3'd1,
		RES_FREE      = 3'd2,
		RES_NOT_ALLOC = 3'd3,
		RES_RANGE     = 3'd4
	} res_t;

	typedef struct packed {
		logic clr_step;
		logic ld_req;
		logic scan_next;
		logic set_bit;
		logic div_step;
		logic free_rd;
		logic clr_bit;
		logic mul;
		logic ld_out;
		res_t res;
	} bba_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic found;
		logic scan_last;
		logic oor;
		logic bit_used;
		logic out_room;
	} bba_stat_t;

endpackage

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clearing pass, word scan for allocate,
// index computation and bit check for free, result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	input  logic                s_op,
	output logic                s_ready,
	input  bba_pkg::bba_stat_t  stat,
	output bba_pkg::bba_cmd_t   cmd
);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_ARD   = 9'b000000100,
		S_ACHK  = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_FRD   = 9'b001000000,
		S_FCHK  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t            state_q, state_d;
	bba_pkg::res_t     res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= bba_pkg::RES_FULL;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	assign s_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_IDLE: begin
				if (s_valid) begin
					cmd.ld_req = 1'b1;
					state_d = (bba_pkg::op_t'(s_op) == bba_pkg::OP_FREE) ? S_DIV : S_ARD;
				end
			end
			// read data of the scan word arrives in the next state
			S_ARD: begin
				state_d = S_ACHK;
			end
			S_ACHK: begin
				if (stat.found) begin
					cmd.set_bit = 1'b1;
					state_d = S_MUL;
				end else if (stat.scan_last) begin
					res_d = bba_pkg::RES_FULL;
					state_d = S_OUT;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_ARD;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				res_d = bba_pkg::RES_ALLOC;
				state_d = S_OUT;
			end
			// block index from one reciprocal multiply
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d = S_FRD;
			end
			S_FRD: begin
				if (stat.oor) begin
					res_d = bba_pkg::RES_RANGE;
					state_d = S_OUT;
				end else begin
					cmd.free_rd = 1'b1;
					state_d = S_FCHK;
				end
			end
			S_FCHK: begin
				if (stat.bit_used) begin
					cmd.clr_bit = 1'b1;
					res_d = bba_pkg::RES_FREE;
				end else begin
					res_d = bba_pkg::RES_NOT_ALLOC;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_room) begin
					cmd.ld_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

[rtl/bba_dp.sv]
// ----------------------------------------------------------------------------
// bba_dp
// Datapath of the allocator: pool registers, bitmap RAM, free-bit search,
// reciprocal multiply for address to index, result and used-count registers.
// ----------------------------------------------------------------------------
module bba_dp #(
	parameter int unsigned MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0]    cfg_data,
	input  logic [bba_pkg::ADDR_W-1:0]    s_addr,
	input  bba_pkg::bba_cmd_t             cmd,
	output bba_pkg::bba_stat_t            stat,
	input  logic                          m_ready,
	output logic                          m_valid,
	output logic [bba_pkg::OUT_W-1:0]     m_data
);

	localparam int unsigned WB    = bba_pkg::WORD_BITS;
	localparam int unsigned DEPTH = (MAX_BLOCKS + WB - 1) / WB;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned XW    = bba_pkg::BIT_W + AW;
	localparam logic [63:0]   LIMIT = 64'(BLOCK_BYTES) << XW;
	// offsets that can still land in the pool fit in DW bits
	localparam int unsigned DW    = (LIMIT > 64'h0000_0000_FFFF_FFFF) ? 32 : $clog2(LIMIT);
	localparam int unsigned LW    = $clog2(BLOCK_BYTES);
	localparam int unsigned SH    = DW + LW;
	localparam int unsigned PW    = (SH + XW > 2 * DW + 1) ? SH + XW : 2 * DW + 1;
	// floor(2^SH / BLOCK_BYTES) + 1 gives an exact quotient below 2^DW
	localparam logic [63:0]   RECIP = ((64'd1 << SH) / 64'(BLOCK_BYTES)) + 64'd1;
	localparam logic [31:0]   BB32  = 32'(BLOCK_BYTES);
	localparam logic [31:0]   MAX32 = 32'(MAX_BLOCKS);

	// pool registers
	logic [bba_pkg::ADDR_W-1:0]  base_q;
	logic [bba_pkg::COUNT_W-1:0] blocks_q;
	logic [bba_pkg::COUNT_W-1:0] n;

	// clearing pass
	logic [AW-1:0] clr_q;
	logic          clr_done_q;

	// scan and index
	logic [AW-1:0]   wa_q;
	logic [DW-1:0]   num_q;
	logic [PW-1:0]   prod_div;
	logic [XW-1:0]   quo_q;
	logic            below_q, ovf_q;
	logic [XW-1:0]   idx_q;
	logic [31:0]     prod_q;
	logic [bba_pkg::COUNT_W-1:0] used_q;

	// output register
	logic                         out_valid_q;
	logic                         ok_q;
	logic [bba_pkg::ADDR_W-1:0]   baddr_q;
	logic [bba_pkg::INDEX_W-1:0]  bidx_q;
	bba_pkg::err_t                err_q;
	logic [bba_pkg::COUNT_W-1:0]  fcnt_q;

	// ram
	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [WB-1:0]   ram_wdata, ram_rdata;
	logic [AW-1:0]   free_wa;
	logic [bba_pkg::BIT_W-1:0] free_bit;

	// search
	logic [31:0]     gb, lim;
	logic [WB-1:0]   free_vec;
	logic [bba_pkg::BIT_W-1:0] enc;
	logic [31:0]     diff;

	assign n = (32'(blocks_q) > MAX32) ? bba_pkg::COUNT_W'(MAX_BLOCKS) : blocks_q;

	assign free_wa  = quo_q[XW-1:bba_pkg::BIT_W];
	assign free_bit = quo_q[bba_pkg::BIT_W-1:0];
	assign gb       = 32'(wa_q) << bba_pkg::BIT_W;
	assign lim      = (32'(n) > gb) ? 32'(n) - gb : 32'd0;
	assign diff     = s_addr - base_q;
	assign prod_div = PW'(num_q) * PW'(RECIP[DW:0]);

	always_comb begin
		free_vec = '0;
		enc      = '0;
		for (int b = 0; b < WB; b++) begin
			free_vec[b] = !ram_rdata[b] && (32'(b) < lim);
		end
		// lowest free bit wins
		for (int b = WB - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				enc = bba_pkg::BIT_W'(b);
			end
		end
	end

	// ram ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = '0;
		priority if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (cmd.set_bit) begin
			ram_we    = 1'b1;
			ram_wdata = ram_rdata | (WB'(1) << enc);
		end else if (cmd.clr_bit) begin
			ram_we    = 1'b1;
			ram_waddr = free_wa;
			ram_wdata = ram_rdata & ~(WB'(1) << free_bit);
		end
	end

	assign ram_raddr = cmd.free_rd ? free_wa : wa_q;

	bba_ram #(
		.WIDTH (WB),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		stat.clear_done = clr_done_q;
		stat.found      = |free_vec;
		stat.scan_last  = (gb + WB) >= 32'(n);
		stat.oor        = below_q || ovf_q || (32'(quo_q) >= 32'(n));
		stat.bit_used   = ram_rdata[free_bit];
		stat.out_room   = !out_valid_q || m_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			blocks_q    <= bba_pkg::COUNT_W'(1024);
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (bba_pkg::cfg_idx_t'(cfg_index))
					bba_pkg::CFG_POOL_BASE:   base_q   <= cfg_data;
					bba_pkg::CFG_POOL_BLOCKS: blocks_q <= cfg_data[bba_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
				if (cmd.res == bba_pkg::RES_ALLOC) begin
					used_q <= used_q + bba_pkg::COUNT_W'(1);
				end else if (cmd.res == bba_pkg::RES_FREE && used_q != '0) begin
					used_q <= used_q - bba_pkg::COUNT_W'(1);
				end
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			wa_q    <= '0;
			num_q   <= diff[DW-1:0];
			below_q <= (s_addr < base_q);
			ovf_q   <= (64'(diff) >= LIMIT);
		end
		if (cmd.scan_next) begin
			wa_q <= wa_q + AW'(1);
		end
		if (cmd.div_step) begin
			quo_q <= prod_div[SH +: XW];
		end
		if (cmd.set_bit) begin
			idx_q <= XW'(gb + 32'(enc));
		end
		if (cmd.mul) begin
			prod_q <= 32'(idx_q) * BB32;
		end
	end

	always_ff @(posedge clk) begin
		logic [bba_pkg::COUNT_W-1:0] nxt;
		nxt = used_q;
		if (cmd.ld_out) begin
			ok_q    <= 1'b0;
			baddr_q <= '0;
			bidx_q  <= '0;
			err_q   <= bba_pkg::ERR_NONE;
			unique case (cmd.res)
				bba_pkg::RES_ALLOC: begin
					ok_q    <= 1'b1;
					baddr_q <= base_q + prod_q;
					bidx_q  <= bba_pkg::INDEX_W'(idx_q);
					nxt     = used_q + bba_pkg::COUNT_W'(1);
				end
				bba_pkg::RES_FULL: begin
					err_q <= bba_pkg::ERR_FULL;
				end
				bba_pkg::RES_FREE: begin
					ok_q   <= 1'b1;
					bidx_q <= bba_pkg::INDEX_W'(quo_q);
					if (used_q != '0) begin
						nxt = used_q - bba_pkg::COUNT_W'(1);
					end
				end
				bba_pkg::RES_NOT_ALLOC: begin
					bidx_q <= bba_pkg::INDEX_W'(quo_q);
					err_q  <= bba_pkg::ERR_NOT_ALLOC;
				end
				bba_pkg::RES_RANGE: begin
					err_q <= bba_pkg::ERR_RANGE;
				end
				default: ;
			endcase
			fcnt_q <= (n > nxt) ? n - nxt : '0;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = {fcnt_q, err_q, bidx_q, baddr_q, ok_q};

endmodule

[rtl/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator of fixed-size blocks over a bitmap of used flags.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           content
//  s_*       in   s_tvalid/s_tready   tuser op, tdata free_addr
//  m_*       out  m_tvalid/m_tready   tdata ok, block_addr, block_index,
//                                     error_code, free_count
//  cfg_*     in   cfg_we              cfg_index, cfg_data
//
// allocate: scans the bitmap one 32-block word at a time, reading each word
// from the bitmap RAM and checking it for a free bit, up to the last word
// free: the block index comes from a single reciprocal multiply; an address
// out of range skips the bitmap read and the bit check
// after reset a clearing pass over every bitmap word holds s_tready low
// one request at a time; the next is taken while a result waits in the
// output register, a full output register stalls the sequencer
module bitmap_block_allocator #(
	parameter int unsigned MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // free_addr
	input  logic                        s_tuser,   // op
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bba_pkg::OUT_W-1:0]   m_tdata    // ok, block_addr, block_index,
	                                               // error_code, free_count
);

	bba_pkg::bba_cmd_t  cmd;
	bba_pkg::bba_stat_t stat;

	bba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_op    (s_tuser),
		.s_ready (s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_addr    (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_ready   (m_tready),
		.m_valid   (m_tvalid),
		.m_data    (m_tdata)
	);

endmodule

[rtl/bba_chk.sv]
// ----------------------------------------------------------------------------
// bba_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bba_pkg::OUT_W-1:0]   m_tdata
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");

	// ok set exactly when no error is reported
	a_ok_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[44:43] == bba_pkg::ERR_NONE)))
		else $error("ok and error code disagree");

	// a full pool gives a zero address and index
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[44:43] == bba_pkg::ERR_FULL
		|-> m_tdata[32:1] == '0 && m_tdata[42:33] == '0)
		else $error("pool full result carries an address");

	// one request at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind bitmap_block_allocator bba_chk u_chk (.*);
